// ===== rtl/core/deadband_keyframe_selector_assert.svh =====
// Assertion macros shared by the deadband keyframe selector RTL.
`ifndef DEADBAND_KEYFRAME_SELECTOR_ASSERT_SVH
`define DEADBAND_KEYFRAME_SELECTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define DKS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dks: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define DKS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dks: next-cycle check failed");
`else
`define DKS_ASSERT_NOW(lbl, ante, cons)
`define DKS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/dks_pkg.sv =====
// Shared types and constants of the deadband keyframe selector.
package dks_pkg;

  localparam int EPS_W = 15;
  localparam int CNT_W = 7;
  localparam int IDX_W = 16;
  localparam int CFG_W = 64;

  localparam logic [EPS_W-1:0] EPS_RST    = 15'd164;
  localparam logic [CFG_W-1:0] ENABLE_RST = {CFG_W{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_RST  = 7'd52;
  localparam logic [CNT_W-1:0] POS_MAX    = {CNT_W{1'b1}};
  localparam logic [IDX_W-1:0] IDX_MAX    = {IDX_W{1'b1}};

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_EPSILON = 2'd0,
    CFG_ENABLE  = 2'd1,
    CFG_COUNT   = 2'd2
  } cfg_reg_t;

  // Control broadcast from the sequencer to every channel cell.
  typedef struct packed {
    logic accept;     // an input beat is taken this cycle
    logic frame_end;  // that beat closes the frame
    logic in_range;   // current position is below the channel count
    logic commit;     // frame closes as a key frame
    logic clear;      // clip closes: committed values return to -1.0
  } cell_ctrl_t;

endpackage

// ===== rtl/core/deadband_keyframe_selector.sv =====
// Top level of the deadband keyframe selector: sequencer, cell chain, output register.
// The result of a key frame is registered: it is on out_* in the cycle after its frame-end beat is taken.
// Throughput: one weight beat per cycle while in_tready is high; each channel cell compares and commits that beat.
// in_tready falls only while a result waits in the output register and out_tready is low.
// Reset (rst_n, synchronous, active low): registers to their defaults, committed values to
// -1.0, position, frame index and pending flags to zero, output empty. No clearing pass.
`include "deadband_keyframe_selector_assert.svh"
module deadband_keyframe_selector #(
  parameter int MAX_CHANNELS = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration write port.
  input  logic                                 cfg_wr_en,
  input  logic [1:0]                           cfg_index,
  input  logic [dks_pkg::CFG_W-1:0]            cfg_wdata,
  // Input stream.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((WEIGHT_BITS+7)/8)*8-1:0]     in_tdata,  // weight
  input  logic                                 in_tlast,  // frame_end
  input  logic                                 in_tuser,  // clip_end
  // Result stream.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [dks_pkg::IDX_W-1:0]            out_tdata, // frame_index
  output logic                                 out_tuser  // edge_frame
);

  logic [dks_pkg::EPS_W-1:0] eps_r;
  logic [dks_pkg::CFG_W-1:0] enable_r;
  logic [dks_pkg::CNT_W-1:0] count_r;

  logic [dks_pkg::CNT_W-1:0] pos_r, pos_nxt;
  logic [dks_pkg::IDX_W-1:0] fc_r, fc_nxt;
  logic                      change_r, change_nxt;
  logic                      clip_r, clip_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [dks_pkg::IDX_W-1:0] out_idx_r;
  logic                      out_edge_r;

  logic                      acc, clip_now, edge_now, hit_now, key_now;
  logic                      emit;
  logic signed [WEIGHT_BITS-1:0] weight;
  logic [MAX_CHANNELS-1:0]   tok, hits;
  dks_pkg::cell_ctrl_t       ctrl;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r    <= dks_pkg::EPS_RST;
      enable_r <= dks_pkg::ENABLE_RST;
      count_r  <= dks_pkg::COUNT_RST;
    end else if (cfg_wr_en) begin
      unique case (dks_pkg::cfg_reg_t'(cfg_index))
        dks_pkg::CFG_EPSILON: eps_r    <= cfg_wdata[dks_pkg::EPS_W-1:0];
        dks_pkg::CFG_ENABLE:  enable_r <= cfg_wdata;
        dks_pkg::CFG_COUNT:   count_r  <= cfg_wdata[dks_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and frame decision.
  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign weight    = in_tdata[WEIGHT_BITS-1:0];
  assign clip_now  = clip_r || in_tuser;
  assign edge_now  = (fc_r == '0) || clip_now;
  assign hit_now   = |hits;
  assign key_now   = edge_now || change_r || hit_now;
  assign emit      = acc && in_tlast && key_now;

  always_comb begin
    ctrl.accept    = acc;
    ctrl.frame_end = in_tlast;
    ctrl.in_range  = (pos_r < count_r);
    ctrl.commit    = emit;
    ctrl.clear     = emit && clip_now;
  end

  // Row of channel cells linked by the position token.
  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_cell
    logic tok_in;
    if (i == 0) begin : g_head
      assign tok_in = 1'b0;
    end else begin : g_link
      assign tok_in = tok[i-1];
    end
    dks_cell #(
      .WEIGHT_BITS (WEIGHT_BITS),
      .FIRST_CELL  (i == 0)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .en_i      (enable_r[i]),
      .epsilon_i (eps_r),
      .weight_i  (weight),
      .tok_i     (tok_in),
      .tok_o     (tok[i]),
      .hit_o     (hits[i])
    );
  end

  // Position, frame index and per-frame flags.
  always_comb begin
    pos_nxt    = pos_r;
    fc_nxt     = fc_r;
    change_nxt = change_r;
    clip_nxt   = clip_r;
    if (acc) begin
      if (in_tlast) begin
        pos_nxt    = '0;
        change_nxt = 1'b0;
        clip_nxt   = 1'b0;
        if (clip_now) begin
          fc_nxt = '0;
        end else if (fc_r != dks_pkg::IDX_MAX) begin
          fc_nxt = fc_r + 1'b1;
        end
      end else begin
        if (pos_r != dks_pkg::POS_MAX) begin
          pos_nxt = pos_r + 1'b1;
        end
        change_nxt = change_r || hit_now;
        clip_nxt   = clip_now;
      end
    end
  end

  // Output register holds a result until the sink takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      fc_r        <= '0;
      change_r    <= 1'b0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      fc_r        <= fc_nxt;
      change_r    <= change_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_idx_r  <= fc_r;
      out_edge_r <= edge_now;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_idx_r;
  assign out_tuser  = out_edge_r;

  // At most one cell owns the current position.
  `DKS_ASSERT_NOW(a_token_onehot0, 1'b1, $onehot0(tok))
  // The first frame of a clip always yields an edge result.
  `DKS_ASSERT_NEXT(a_first_frame_keyed, acc && in_tlast && (fc_r == '0), out_valid_r && out_edge_r)
  // A clip end restarts the frame index.
  `DKS_ASSERT_NEXT(a_clip_restart, acc && in_tlast && clip_now, fc_r == '0)
  // A frame end returns the position to the first channel.
  `DKS_ASSERT_NEXT(a_frame_restart, acc && in_tlast, (pos_r == '0) && tok[0])

endmodule

// ===== rtl/core/dks_cell.sv =====
// One channel cell: committed and pending weight, change compare, position token.
module dks_cell #(
  parameter int  WEIGHT_BITS = 16,
  parameter bit  FIRST_CELL  = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dks_pkg::cell_ctrl_t           ctrl,
  input  logic                          en_i,
  input  logic [dks_pkg::EPS_W-1:0]     epsilon_i,
  input  logic signed [WEIGHT_BITS-1:0] weight_i,
  input  logic                          tok_i,
  output logic                          tok_o,
  output logic                          hit_o
);

  localparam int CMP_W = (WEIGHT_BITS + 1 > dks_pkg::EPS_W) ? WEIGHT_BITS + 1
                                                             : dks_pkg::EPS_W;
  localparam logic [WEIGHT_BITS-1:0] MINUS_ONE = {2'b11, {(WEIGHT_BITS-2){1'b0}}};

  logic                          tok_r, tok_nxt;
  logic                          pvalid_r, pvalid_nxt;
  logic signed [WEIGHT_BITS-1:0] last_r, last_nxt;
  logic signed [WEIGHT_BITS-1:0] pend_r;
  logic                          sel;
  logic signed [WEIGHT_BITS:0]   diff;
  logic [WEIGHT_BITS:0]          absd;

  // This cell owns the current beat when it holds the token, is enabled and the position is in range.
  assign sel = ctrl.accept & ctrl.in_range & tok_r & en_i;

  // Distance to the committed value, compared against the threshold.
  always_comb begin
    diff = {weight_i[WEIGHT_BITS-1], weight_i} - {last_r[WEIGHT_BITS-1], last_r};
    absd = diff[WEIGHT_BITS] ? (WEIGHT_BITS+1)'(-diff) : (WEIGHT_BITS+1)'(diff);
  end
  assign hit_o = sel & (CMP_W'(absd) >= CMP_W'(epsilon_i));
  assign tok_o = tok_r;

  // Token shifts one cell per beat and restarts at the first cell on frame end.
  always_comb begin
    tok_nxt = tok_r;
    if (ctrl.accept) begin
      tok_nxt = ctrl.frame_end ? FIRST_CELL : tok_i;
    end
  end

  // Pending valid is cleared at each frame end.
  always_comb begin
    pvalid_nxt = pvalid_r;
    if (ctrl.accept && ctrl.frame_end) begin
      pvalid_nxt = 1'b0;
    end else if (sel) begin
      pvalid_nxt = 1'b1;
    end
  end

  // Commit the frame's weight on a key frame; the clip end restores -1.0.
  always_comb begin
    last_nxt = last_r;
    priority if (ctrl.clear) begin
      last_nxt = MINUS_ONE;
    end else if (ctrl.commit && sel) begin
      last_nxt = weight_i;
    end else if (ctrl.commit && pvalid_r) begin
      last_nxt = pend_r;
    end else begin
      last_nxt = last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r    <= FIRST_CELL;
      pvalid_r <= 1'b0;
      last_r   <= MINUS_ONE;
    end else begin
      tok_r    <= tok_nxt;
      pvalid_r <= pvalid_nxt;
      last_r   <= last_nxt;
    end
  end

  // Pending weight needs no reset; it is read only when pending valid is set.
  always_ff @(posedge clk) begin
    if (sel) begin
      pend_r <= weight_i;
    end
  end

endmodule
